>>> src/irlg_pkg.sv
// Shared widths, types and constant tables for the IMEI Luhn generator.
package irlg_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned NIB_COUNT   = 16;
  localparam int unsigned NIB_VALS    = 16;
  localparam int unsigned WORD_W      = NIB_W * NIB_COUNT;
  localparam int unsigned CODE_COUNT  = 17;
  localparam int unsigned SEL_W       = 5;
  localparam int unsigned CODE_W      = 7;
  localparam int unsigned BODY_DIGITS = 12;
  localparam int unsigned BIN_W       = 40;
  localparam int unsigned BCD_W       = NIB_W * BODY_DIGITS;
  localparam int unsigned IMEI_W      = 50;
  localparam int unsigned CHK_W       = 4;
  localparam int unsigned SUM_W       = 7;
  localparam int unsigned BYTE_VALS   = 256;

  localparam logic [63:0]       BODY_MOD_L = 64'd1000000000000;
  localparam logic [BIN_W-1:0]  BODY_MOD   = BIN_W'(BODY_MOD_L);
  localparam logic [IMEI_W-1:0] CODE_SCALE = 50'd10000000000000;

  typedef logic [SEL_W-1:0] sel_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } term_t;

  typedef logic [CODE_COUNT-1:0][CODE_W-1:0]               code_tab_t;
  typedef logic [BYTE_VALS-1:0][SEL_W-1:0]                 sel_tab_t;
  typedef logic [CODE_COUNT-1:0][7:0]                      code_bcd_tab_t;
  typedef logic [CODE_COUNT-1:0][IMEI_W-1:0]               code_scl_tab_t;
  typedef logic [NIB_COUNT-1:0][NIB_VALS-1:0][BIN_W-1:0]   bin_tab_t;
  typedef logic [NIB_COUNT-1:0][NIB_VALS-1:0][BCD_W-1:0]   bcd_tab_t;

  // Reporting-body codes, highest entry first; entry 0 (code 1) is listed last.
  localparam code_tab_t RB_CODES = {
    7'd99, 7'd98, 7'd91, 7'd86, 7'd54, 7'd53, 7'd52, 7'd51, 7'd50,
    7'd49, 7'd45, 7'd44, 7'd35, 7'd33, 7'd30, 7'd10, 7'd1
  };

  function automatic sel_tab_t build_sel();
    sel_tab_t t;
    for (int i = 0; i < BYTE_VALS; i++) begin
      t[i] = SEL_W'(i % CODE_COUNT);
    end
    return t;
  endfunction

  function automatic code_bcd_tab_t build_code_bcd();
    code_bcd_tab_t t;
    for (int i = 0; i < CODE_COUNT; i++) begin
      t[i] = {4'(RB_CODES[i] / 10), 4'(RB_CODES[i] % 10)};
    end
    return t;
  endfunction

  function automatic code_scl_tab_t build_code_scl();
    code_scl_tab_t t;
    for (int i = 0; i < CODE_COUNT; i++) begin
      t[i] = IMEI_W'(RB_CODES[i]) * CODE_SCALE;
    end
    return t;
  endfunction

  // n * 16^p mod 10^12 for every nibble place and value.
  function automatic bin_tab_t build_bin();
    bin_tab_t    t;
    logic [63:0] pw;
    logic [63:0] prod;
    pw = 64'd1;
    for (int p = 0; p < NIB_COUNT; p++) begin
      for (int n = 0; n < NIB_VALS; n++) begin
        prod    = (64'(n) * pw) % BODY_MOD_L;
        t[p][n] = BIN_W'(prod);
      end
      pw = (pw * 64'd16) % BODY_MOD_L;
    end
    return t;
  endfunction

  function automatic logic [BCD_W-1:0] to_bcd(input logic [63:0] val);
    logic [63:0]      v;
    logic [BCD_W-1:0] r;
    v = val;
    for (int d = 0; d < BODY_DIGITS; d++) begin
      r[NIB_W*d +: NIB_W] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  function automatic bcd_tab_t build_bcd(input bin_tab_t b);
    bcd_tab_t t;
    for (int p = 0; p < NIB_COUNT; p++) begin
      for (int n = 0; n < NIB_VALS; n++) begin
        t[p][n] = to_bcd(64'(b[p][n]));
      end
    end
    return t;
  endfunction

  localparam sel_tab_t      SEL_TAB    = build_sel();
  localparam code_bcd_tab_t CODE_BCD   = build_code_bcd();
  localparam code_scl_tab_t CODE_SCL   = build_code_scl();
  localparam bin_tab_t      TERM_BIN   = build_bin();
  localparam bcd_tab_t      TERM_BCD   = build_bcd(TERM_BIN);

endpackage

>>> src/irlg_if.sv
// Valid/ready channel interfaces for the IMEI Luhn generator.
interface irlg_in_if;
  logic                           valid;
  logic                           ready;
  logic [irlg_pkg::BYTE_W-1:0]    random_index_byte;
  logic [irlg_pkg::WORD_W-1:0]    random_word;

  modport source (output valid, random_index_byte, random_word, input ready);
  modport sink   (input valid, random_index_byte, random_word, output ready);
endinterface

interface irlg_out_if;
  logic                           valid;
  logic                           ready;
  logic [irlg_pkg::IMEI_W-1:0]    imei_value;
  logic [irlg_pkg::CHK_W-1:0]     check_digit;

  modport source (output valid, imei_value, check_digit, input ready);
  modport sink   (input valid, imei_value, check_digit, output ready);
endinterface

>>> src/imei_random_luhn_generator.sv
// Top level of the IMEI generator: lookup stage, residue adder tree, Luhn stages.
//
//   channel   dir  beat payload                                handshake
//   in_chan   in   random_index_byte[7:0], random_word[63:0]    valid/ready
//   out_chan  out  imei_value[49:0], check_digit[3:0]           valid/ready
//
// One beat in per cycle while out_chan does not stall, one result out per beat.
// Seven register stages: nibble lookup, four adder-tree levels, Luhn sum, check add.
// Each stage holds its own valid bit; ready ripples back stage by stage, so a
// stall on out_chan fills bubbles first and then holds every stage in place.
// Synchronous active-low reset clears the valid bits only.
module imei_random_luhn_generator (
  input  logic         clk,
  input  logic         rst_n,
  irlg_in_if.sink      in_chan,
  irlg_out_if.source   out_chan
);

  localparam int unsigned N0 = irlg_pkg::NIB_COUNT;
  localparam int unsigned N1 = N0 / 2;
  localparam int unsigned N2 = N1 / 2;
  localparam int unsigned N3 = N2 / 2;
  localparam int unsigned N4 = N3 / 2;

  logic                        s_vld;
  logic                        s_rdy;
  irlg_pkg::sel_t              s_sel;
  irlg_pkg::term_t [N0-1:0]    s_terms;

  logic [3:0]                  f_vld;
  logic [3:0]                  f_rdy;
  irlg_pkg::sel_t              f1_sel;
  irlg_pkg::sel_t              f2_sel;
  irlg_pkg::sel_t              f3_sel;
  irlg_pkg::sel_t              f4_sel;
  irlg_pkg::term_t [N1-1:0]    f1_terms;
  irlg_pkg::term_t [N2-1:0]    f2_terms;
  irlg_pkg::term_t [N3-1:0]    f3_terms;
  irlg_pkg::term_t [N4-1:0]    f4_terms;

  logic                        l_rdy;

  irlg_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (s_rdy),
    .in_byte   (in_chan.random_index_byte),
    .in_word   (in_chan.random_word),
    .out_valid (s_vld),
    .out_ready (f_rdy[0]),
    .out_sel   (s_sel),
    .out_terms (s_terms)
  );

  assign in_chan.ready = s_rdy;

  irlg_fold #(.N_IN(N0)) u_fold1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_vld),
    .in_ready  (f_rdy[0]),
    .in_sel    (s_sel),
    .in_terms  (s_terms),
    .out_valid (f_vld[0]),
    .out_ready (f_rdy[1]),
    .out_sel   (f1_sel),
    .out_terms (f1_terms)
  );

  irlg_fold #(.N_IN(N1)) u_fold2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld[0]),
    .in_ready  (f_rdy[1]),
    .in_sel    (f1_sel),
    .in_terms  (f1_terms),
    .out_valid (f_vld[1]),
    .out_ready (f_rdy[2]),
    .out_sel   (f2_sel),
    .out_terms (f2_terms)
  );

  irlg_fold #(.N_IN(N2)) u_fold3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld[1]),
    .in_ready  (f_rdy[2]),
    .in_sel    (f2_sel),
    .in_terms  (f2_terms),
    .out_valid (f_vld[2]),
    .out_ready (f_rdy[3]),
    .out_sel   (f3_sel),
    .out_terms (f3_terms)
  );

  irlg_fold #(.N_IN(N3)) u_fold4 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld[2]),
    .in_ready  (f_rdy[3]),
    .in_sel    (f3_sel),
    .in_terms  (f3_terms),
    .out_valid (f_vld[3]),
    .out_ready (l_rdy),
    .out_sel   (f4_sel),
    .out_terms (f4_terms)
  );

  irlg_luhn u_luhn (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_vld[3]),
    .in_ready  (l_rdy),
    .in_sel    (f4_sel),
    .in_term   (f4_terms[0]),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_imei  (out_chan.imei_value),
    .out_chk   (out_chan.check_digit)
  );

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid straight after reset");

  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
      !in_chan.ready |-> (s_vld && (&f_vld) && !l_rdy && out_chan.valid))
    else $error("input stalled while a stage has room");

  a_chk_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_chan.valid |-> (out_chan.check_digit <= 4'd9))
    else $error("check digit above nine");

  a_imei_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_chan.valid |-> (out_chan.imei_value <= 50'd999999999999999))
    else $error("IMEI exceeds fifteen digits");

endmodule

>>> src/irlg_split.sv
// First stage: code select and per-nibble residue lookup of the random word.
module irlg_split (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [irlg_pkg::BYTE_W-1:0]               in_byte,
  input  logic [irlg_pkg::WORD_W-1:0]               in_word,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output irlg_pkg::sel_t                            out_sel,
  output irlg_pkg::term_t [irlg_pkg::NIB_COUNT-1:0] out_terms
);

  logic                                      vld_r;
  irlg_pkg::sel_t                            sel_r;
  irlg_pkg::sel_t                            sel_nxt;
  irlg_pkg::term_t [irlg_pkg::NIB_COUNT-1:0] terms_r;
  irlg_pkg::term_t [irlg_pkg::NIB_COUNT-1:0] terms_nxt;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    sel_nxt = irlg_pkg::SEL_TAB[in_byte];
    for (int i = 0; i < irlg_pkg::NIB_COUNT; i++) begin
      terms_nxt[i].bin = irlg_pkg::TERM_BIN[i][in_word[irlg_pkg::NIB_W*i +: irlg_pkg::NIB_W]];
      terms_nxt[i].bcd = irlg_pkg::TERM_BCD[i][in_word[irlg_pkg::NIB_W*i +: irlg_pkg::NIB_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sel_r   <= sel_nxt;
      terms_r <= terms_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_sel   = sel_r;
  assign out_terms = terms_r;

endmodule

>>> src/irlg_fold.sv
// One level of the residue adder tree: pairwise sums mod 10^12 in binary and BCD.
module irlg_fold #(
  parameter int unsigned N_IN = irlg_pkg::NIB_COUNT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  irlg_pkg::sel_t                   in_sel,
  input  irlg_pkg::term_t [N_IN-1:0]       in_terms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output irlg_pkg::sel_t                   out_sel,
  output irlg_pkg::term_t [N_IN/2-1:0]     out_terms
);

  localparam int unsigned N_OUT = N_IN / 2;
  localparam int unsigned BW    = irlg_pkg::BIN_W;
  localparam int unsigned DW    = irlg_pkg::BCD_W;
  localparam logic [DW-1:0] SIXES = {irlg_pkg::BODY_DIGITS{4'h6}};

  function automatic logic [BW-1:0] mod_add(input logic [BW-1:0] a, input logic [BW-1:0] b);
    logic [BW:0] s;
    logic [BW:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, irlg_pkg::BODY_MOD};
    return d[BW] ? s[BW-1:0] : d[BW-1:0];
  endfunction

  // Decimal add via +6 bias; carry out of the top digit is the mod 10^12 drop.
  function automatic logic [DW-1:0] bcd_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0]   t1;
    logic [DW:0]   t2;
    logic [DW:0]   cin;
    logic [DW-1:0] r;
    t1  = {1'b0, a} + {1'b0, SIXES};
    t2  = t1 + {1'b0, b};
    cin = t2 ^ t1 ^ {1'b0, b};
    for (int k = 0; k < irlg_pkg::BODY_DIGITS; k++) begin
      r[irlg_pkg::NIB_W*k +: irlg_pkg::NIB_W] = cin[irlg_pkg::NIB_W*(k+1)]
          ? t2[irlg_pkg::NIB_W*k +: irlg_pkg::NIB_W]
          : t2[irlg_pkg::NIB_W*k +: irlg_pkg::NIB_W] - 4'd6;
    end
    return r;
  endfunction

  logic                          vld_r;
  irlg_pkg::sel_t                sel_r;
  irlg_pkg::term_t [N_OUT-1:0]   terms_r;
  irlg_pkg::term_t [N_OUT-1:0]   terms_nxt;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    for (int j = 0; j < N_OUT; j++) begin
      terms_nxt[j].bin = mod_add(in_terms[2*j].bin, in_terms[2*j+1].bin);
      terms_nxt[j].bcd = bcd_add(in_terms[2*j].bcd, in_terms[2*j+1].bcd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sel_r   <= in_sel;
      terms_r <= terms_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_sel   = sel_r;
  assign out_terms = terms_r;

endmodule

>>> src/irlg_luhn.sv
// Last two stages: Luhn digit sum and base value, then check digit and final IMEI.
module irlg_luhn (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  irlg_pkg::sel_t              in_sel,
  input  irlg_pkg::term_t             in_term,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [irlg_pkg::IMEI_W-1:0] out_imei,
  output logic [irlg_pkg::CHK_W-1:0]  out_chk
);

  localparam int unsigned SW     = irlg_pkg::SUM_W;
  localparam int unsigned NW     = irlg_pkg::NIB_W;
  localparam int unsigned SUMS   = 1 << SW;
  localparam int unsigned HALF   = irlg_pkg::BODY_DIGITS / 2;

  typedef logic [SUMS-1:0][irlg_pkg::CHK_W-1:0] chk_tab_t;

  function automatic chk_tab_t build_chk();
    chk_tab_t t;
    for (int s = 0; s < SUMS; s++) begin
      t[s] = irlg_pkg::CHK_W'((10 - s % 10) % 10);
    end
    return t;
  endfunction

  localparam chk_tab_t CHK_TAB = build_chk();

  function automatic logic [NW-1:0] dbl(input logic [NW-1:0] d);
    logic [NW-1:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  logic                        a_vld_r;
  logic                        a_ready;
  logic [SW-1:0]               sum_r;
  logic [SW-1:0]               sum_nxt;
  logic [SW-1:0]               sum_plain;
  logic [SW-1:0]               sum_dbl;
  logic [irlg_pkg::IMEI_W-1:0] base_r;
  logic [irlg_pkg::IMEI_W-1:0] base_nxt;
  logic [irlg_pkg::IMEI_W-1:0] body_w;
  logic [7:0]                  code_bcd;
  logic                        b_vld_r;
  logic                        b_ready;
  logic [irlg_pkg::CHK_W-1:0]  chk_r;
  logic [irlg_pkg::CHK_W-1:0]  chk_nxt;
  logic [irlg_pkg::IMEI_W-1:0] imei_r;
  logic [irlg_pkg::IMEI_W-1:0] imei_nxt;

  assign b_ready  = !b_vld_r || out_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign in_ready = a_ready;

  // Body digit k lands at place 13-k: even k doubled, odd k summed as is.
  always_comb begin
    code_bcd  = irlg_pkg::CODE_BCD[in_sel];
    sum_plain = SW'(code_bcd[7:4]);
    sum_dbl   = SW'(dbl(code_bcd[3:0]));
    for (int k = 0; k < HALF; k++) begin
      sum_plain = sum_plain + SW'(in_term.bcd[NW*(2*k+1) +: NW]);
      sum_dbl   = sum_dbl + SW'(dbl(in_term.bcd[NW*(2*k) +: NW]));
    end
    sum_nxt  = sum_plain + sum_dbl;
    body_w   = irlg_pkg::IMEI_W'(in_term.bin);
    base_nxt = irlg_pkg::CODE_SCL[in_sel] + (body_w << 3) + (body_w << 1);
  end

  always_comb begin
    chk_nxt  = CHK_TAB[sum_r];
    imei_nxt = base_r + irlg_pkg::IMEI_W'(chk_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_r <= in_valid;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      sum_r  <= sum_nxt;
      base_r <= base_nxt;
    end
    if (b_ready && a_vld_r) begin
      chk_r  <= chk_nxt;
      imei_r <= imei_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_imei  = imei_r;
  assign out_chk   = chk_r;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the IMEI Luhn check digit generator.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [irlg_pkg::IMEI_W-1:0] imei;
    logic [irlg_pkg::CHK_W-1:0]  chk;
  } imei_result_t;

  localparam logic [63:0] SERIAL_MOD = 64'd1000000000000;
  localparam logic [63:0] BODY_SCALE = 64'd10000000000000;
  localparam int unsigned NUM_BODIES = 17;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   sink_hold;
  bit   no_idle;

  imei_result_t pending_imei[$];
  logic [6:0]   body_codes[NUM_BODIES];

  irlg_in_if  in_chan();
  irlg_out_if out_chan();

  imei_random_luhn_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    body_codes = '{7'd1, 7'd10, 7'd30, 7'd33, 7'd35, 7'd44, 7'd45, 7'd49, 7'd50,
                   7'd51, 7'd52, 7'd53, 7'd54, 7'd86, 7'd91, 7'd98, 7'd99};
  end

  function automatic imei_result_t luhn_imei(input logic [irlg_pkg::BYTE_W-1:0] idx,
                                             input logic [irlg_pkg::WORD_W-1:0] word);
    logic [63:0]  serial;
    logic [63:0]  number;
    logic [63:0]  rest;
    logic [3:0]   places[15];
    int unsigned  sum;
    int unsigned  dbl;
    imei_result_t r;
    serial = word % SERIAL_MOD;
    number = 64'(body_codes[idx % NUM_BODIES]) * BODY_SCALE + serial * 64'd10;
    rest   = number;
    for (int p = 14; p >= 0; p--) begin
      places[p] = 4'(rest % 64'd10);
      rest      = rest / 64'd10;
    end
    sum = 0;
    for (int p = 0; p <= 12; p += 2) sum += places[p];
    for (int p = 1; p <= 13; p += 2) begin
      dbl = places[p] * 2;
      if (dbl >= 10) dbl = 1 + dbl % 10;
      sum += dbl;
    end
    r.chk  = irlg_pkg::CHK_W'((10 - sum % 10) % 10);
    r.imei = irlg_pkg::IMEI_W'(number + 64'(r.chk));
    return r;
  endfunction

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic send_item(input logic [irlg_pkg::BYTE_W-1:0] idx,
                           input logic [irlg_pkg::WORD_W-1:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid             <= 1'b1;
    in_chan.random_index_byte <= idx;
    in_chan.random_word       <= word;
    forever begin
      @(posedge clk);
      if (in_chan.ready) break;
    end
    pending_imei.push_back(luhn_imei(idx, word));
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_imei.size() != 0) @(posedge clk);
  endtask

  function automatic logic [irlg_pkg::WORD_W-1:0] rand_word();
    logic [irlg_pkg::WORD_W-1:0] w;
    case ($urandom_range(0, 5))
      0: w = irlg_pkg::WORD_W'($urandom_range(0, 1000));
      1: w = SERIAL_MOD * irlg_pkg::WORD_W'($urandom_range(0, 1000))
             - irlg_pkg::WORD_W'($urandom_range(0, 2));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // result channel: check each beat against the oldest expectation
  always @(posedge clk) begin
    imei_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sink_hold = no_idle ? 0 : $urandom_range(0, 3);
      if (pending_imei.size() == 0) begin
        report($sformatf("result with no item pending, imei %0d", out_chan.imei_value));
      end else begin
        want = pending_imei.pop_front();
        if (out_chan.imei_value !== want.imei)
          report($sformatf("imei_value got %0d expected %0d", out_chan.imei_value, want.imei));
        if (out_chan.check_digit !== want.chk)
          report($sformatf("check_digit got %0d expected %0d", out_chan.check_digit, want.chk));
      end
    end
  end

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_chan.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  task automatic test_code_table();
    for (int i = 0; i < NUM_BODIES; i++) begin
      send_item(irlg_pkg::BYTE_W'(i + NUM_BODIES * $urandom_range(0, 14)), rand_word());
    end
  endtask

  task automatic test_field_extremes();
    send_item(8'd0,   64'd0);
    send_item(8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(8'd16,  SERIAL_MOD - 64'd1);
    send_item(8'd17,  SERIAL_MOD);
    send_item(8'd254, 64'h8000_0000_0000_0000);
    send_item(8'd0,   SERIAL_MOD - 64'd1);
    send_item(8'd33,  64'h7FFF_FFFF_FFFF_FFFF);
    send_item(8'd128, 64'd1);
  endtask

  task automatic test_random_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(irlg_pkg::BYTE_W'($urandom), rand_word());
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_mixed(40);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    test_random_mixed(12);
    wait_for_drain();
    test_random_mixed(12);
  endtask

  initial begin
    mismatches                = 0;
    sink_hold                 = 0;
    no_idle                   = 1'b0;
    rst_n                     = 1'b0;
    in_chan.valid             = 1'b0;
    in_chan.random_index_byte = '0;
    in_chan.random_word       = '0;
    out_chan.ready            = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_code_table();
    test_field_extremes();
    test_random_mixed(380);
    test_drain_pause();
    test_back_to_back();
    test_random_mixed(380);

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (pending_imei.size() != 0)
      report($sformatf("%0d results never arrived", pending_imei.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
